>>> sv/stl_pkg.sv
package stl_pkg;

	// Token kind codes carried in the low nibble of a result beat.
	localparam logic [3:0] KIND_NUM     = 4'd0;
	localparam logic [3:0] KIND_COLON   = 4'd1;
	localparam logic [3:0] KIND_COMMA   = 4'd2;
	localparam logic [3:0] KIND_LPAREN  = 4'd3;
	localparam logic [3:0] KIND_RPAREN  = 4'd4;
	localparam logic [3:0] KIND_LBRACE  = 4'd5;
	localparam logic [3:0] KIND_RBRACE  = 4'd6;
	localparam logic [3:0] KIND_FUNC    = 4'd7;
	localparam logic [3:0] KIND_INT64   = 4'd8;
	localparam logic [3:0] KIND_RET     = 4'd9;
	localparam logic [3:0] KIND_IDENT   = 4'd10;
	localparam logic [3:0] KIND_END     = 4'd11;
	localparam logic [3:0] KIND_UNKNOWN = 4'd12;

	// Scan mode codes.
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_NUM   = 2'd1;
	localparam logic [1:0] MODE_IDENT = 2'd2;

	// Input op codes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	// Number of keywords and the width of the candidate mask.
	localparam int NUM_KW = 3;

	// One result token as held in the output buffer.
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  bad;
		logic        last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// Keyword lengths: func, Int64, ret.
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] n;
		unique case (k)
			2'd0: n = 3'd4;
			2'd1: n = 3'd5;
			2'd2: n = 3'd3;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Keyword kinds in the same order.
	function automatic logic [3:0] kw_kind(input logic [1:0] k);
		logic [3:0] n;
		unique case (k)
			2'd0: n = KIND_FUNC;
			2'd1: n = KIND_INT64;
			2'd2: n = KIND_RET;
			default: n = KIND_IDENT;
		endcase
		return n;
	endfunction

	// Character i of keyword k; zero past its end.
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		unique case ({k, i})
			{2'd0, 3'd0}: c = "f";
			{2'd0, 3'd1}: c = "u";
			{2'd0, 3'd2}: c = "n";
			{2'd0, 3'd3}: c = "c";
			{2'd1, 3'd0}: c = "I";
			{2'd1, 3'd1}: c = "n";
			{2'd1, 3'd2}: c = "t";
			{2'd1, 3'd3}: c = "6";
			{2'd1, 3'd4}: c = "4";
			{2'd2, 3'd0}: c = "r";
			{2'd2, 3'd1}: c = "e";
			{2'd2, 3'd2}: c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> sv/script_token_lexer.sv
// Channel   Direction  tdata                                   tuser  tlast
// s_*       in         ch[7:0]                                 op     -
// m_*       out        kind, start, length, bad_char (48 bits) -      last_of_run
//
// One source byte is taken per cycle while the buffer has room. The scan state is updated in that cycle,
// and the results sit in a two-entry output buffer, on m_* from the cycle after acceptance.
// A punctuation or unknown byte that ends a pending token, or end of source with a token
// pending, gives two result beats and holds the input while the buffer drains. Every other
// byte allows one byte per cycle while m_tready is high. arst_n clears the scan state and
// empties the buffer. The input is accepted while the buffer is empty or its last beat leaves.
module script_token_lexer #(
	parameter int POS_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] token_kind, [19:4] token_start, [35:20] token_length,
	// [43:36] bad_char, [47:44] zero
	output logic [47:0] m_tdata,
	output logic        m_tlast
);

	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

	// Scan state.
	logic [1:0]           mode_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] begin_q;
	logic [2:0]           hits_q;

	// Output buffer: slot 0 is on the bus.
	stl_pkg::token_t      buf_q [2];
	logic [1:0]           cnt_q;

	logic                 in_fire;
	logic                 out_fire;

	logic [1:0]           mode_d;
	logic [POS_WIDTH-1:0] pos_d;
	logic [POS_WIDTH-1:0] begin_d;
	logic [2:0]           hits_d;
	stl_pkg::token_t      res [2];
	logic [1:0]           res_n;

	logic                 pending;
	logic [POS_WIDTH-1:0] tok_len;
	logic [POS_WIDTH-1:0] pos_adv;
	logic [3:0]           flush_kind;
	stl_pkg::token_t      flush_tok;
	stl_pkg::token_t      byte_tok;
	logic                 byte_tok_v;
	logic [2:0]           hits_cont;
	logic [2:0]           hits_first;

	function automatic logic [15:0] low16(input logic [POS_WIDTH-1:0] v);
		logic [POS_WIDTH+15:0] e;
		e = {16'h0000, v};
		return e[15:0];
	endfunction

	function automatic logic [POS_WIDTH-1:0] widen3(input logic [2:0] v);
		logic [POS_WIDTH+2:0] e;
		e = {{POS_WIDTH{1'b0}}, v};
		return e[POS_WIDTH-1:0];
	endfunction

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);

	// Shared terms: pending token, its length, saturated advance, keyword masks.
	always_comb begin
		pending = (mode_q == stl_pkg::MODE_NUM) || (mode_q == stl_pkg::MODE_IDENT);
		tok_len = pos_q - begin_q;
		pos_adv = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

		flush_kind = (mode_q == stl_pkg::MODE_NUM) ? stl_pkg::KIND_NUM : stl_pkg::KIND_IDENT;
		if (mode_q == stl_pkg::MODE_IDENT) begin
			for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
				if (hits_q[k] && (tok_len == widen3(stl_pkg::kw_len(2'(k))))) begin
					flush_kind = stl_pkg::kw_kind(2'(k));
				end
			end
		end
		flush_tok.kind   = flush_kind;
		flush_tok.start  = low16(begin_q);
		flush_tok.length = low16(tok_len);
		flush_tok.bad    = 8'h00;
		flush_tok.last   = 1'b0;

		hits_cont  = '0;
		hits_first = '0;
		for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
			if (hits_q[k] && (pos_q != POS_MAX) &&
			    (tok_len < widen3(stl_pkg::kw_len(2'(k)))) &&
			    (stl_pkg::kw_char(2'(k), tok_len[2:0]) == s_tdata)) begin
				hits_cont[k] = 1'b1;
			end
			if (stl_pkg::kw_char(2'(k), 3'd0) == s_tdata) begin
				hits_first[k] = 1'b1;
			end
		end
	end

	// Single-byte punctuation and unknown bytes.
	always_comb begin
		byte_tok.start  = low16(pos_q);
		byte_tok.length = 16'd1;
		byte_tok.bad    = 8'h00;
		byte_tok.last   = 1'b0;
		unique case (s_tdata)
			":": byte_tok.kind = stl_pkg::KIND_COLON;
			",": byte_tok.kind = stl_pkg::KIND_COMMA;
			"(": byte_tok.kind = stl_pkg::KIND_LPAREN;
			")": byte_tok.kind = stl_pkg::KIND_RPAREN;
			"{": byte_tok.kind = stl_pkg::KIND_LBRACE;
			"}": byte_tok.kind = stl_pkg::KIND_RBRACE;
			default: begin
				byte_tok.kind = stl_pkg::KIND_UNKNOWN;
				byte_tok.bad  = s_tdata;
			end
		endcase
		byte_tok_v = !stl_pkg::is_space(s_tdata) && !stl_pkg::is_digit(s_tdata) &&
		             !stl_pkg::is_alpha(s_tdata);
	end

	// Next scan state and the results of the current beat.
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		begin_d = begin_q;
		hits_d  = hits_q;
		res[0]  = flush_tok;
		res[1]  = byte_tok;
		res_n   = 2'd0;

		if (s_tuser == stl_pkg::OP_EOS) begin
			// End of source: flush, emit END, return to reset state.
			res[1].kind   = stl_pkg::KIND_END;
			res[1].start  = low16(pos_q);
			res[1].length = 16'd0;
			res[1].bad    = 8'h00;
			if (pending) begin
				res_n = 2'd2;
			end else begin
				res[0] = res[1];
				res_n  = 2'd1;
			end
			mode_d  = stl_pkg::MODE_IDLE;
			pos_d   = '0;
			begin_d = '0;
			hits_d  = '0;
		end else if ((mode_q == stl_pkg::MODE_NUM) && stl_pkg::is_digit(s_tdata)) begin
			pos_d = pos_adv;
		end else if ((mode_q == stl_pkg::MODE_IDENT) &&
		             (stl_pkg::is_alpha(s_tdata) || stl_pkg::is_digit(s_tdata))) begin
			hits_d = hits_cont;
			pos_d  = pos_adv;
		end else begin
			// The byte ends any pending token, then starts fresh.
			pos_d  = pos_adv;
			hits_d = '0;
			mode_d = stl_pkg::MODE_IDLE;
			if (stl_pkg::is_digit(s_tdata)) begin
				mode_d  = stl_pkg::MODE_NUM;
				begin_d = pos_q;
			end else if (stl_pkg::is_alpha(s_tdata)) begin
				mode_d  = stl_pkg::MODE_IDENT;
				begin_d = pos_q;
				hits_d  = hits_first;
			end
			if (pending && byte_tok_v) begin
				res_n = 2'd2;
			end else if (pending) begin
				res_n = 2'd1;
			end else if (byte_tok_v) begin
				res[0] = byte_tok;
				res_n  = 2'd1;
			end
		end

		// Mark the final beat of this item.
		if (res_n == 2'd2) begin
			res[1].last = 1'b1;
		end else begin
			res[0].last = 1'b1;
		end
	end

	// Scan state and buffer fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stl_pkg::MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			hits_q  <= '0;
			cnt_q   <= 2'd0;
		end else begin
			if (in_fire) begin
				mode_q  <= mode_d;
				pos_q   <= pos_d;
				begin_q <= begin_d;
				hits_q  <= hits_d;
				cnt_q   <= res_n;
			end else if (out_fire) begin
				cnt_q   <= cnt_q - 2'd1;
			end
		end
	end

	// Buffer payload: load on a new beat, shift on a pop.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_q[0] <= res[0];
			buf_q[1] <= res[1];
		end else if (out_fire) begin
			buf_q[0] <= buf_q[1];
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {4'h0, buf_q[0].bad, buf_q[0].length, buf_q[0].start, buf_q[0].kind};
	assign m_tlast  = buf_q[0].last;

endmodule

>>> tb/sv/script_token_lexer_tb.sv
module script_token_lexer_tb;

	localparam int    LEX_POS_WIDTH = 16;
	localparam int    QUIET_LIMIT   = 2000;
	localparam int    HOLD_CYCLES   = 300;
	localparam int    PHASE_ITEMS   = 500;
	localparam string LETTERS       = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam string ALNUMS        =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
	localparam string DIGITS        = "0123456789";
	localparam string PUNCT         = ":,(){}";

	// Expected-token tracker: mirrors the lexer state and holds the tokens still owed.
	class token_scoreboard;
		logic [1:0]      mode;
		logic [15:0]     pos;
		logic [15:0]     tbegin;
		logic [2:0]      hits;
		string           kw_word[3];
		logic [3:0]      kw_kinds[3];
		stl_pkg::token_t expected_tokens[$];
		int              errors;

		function new();
			kw_word = '{"func", "Int64", "ret"};
			kw_kinds = '{stl_pkg::KIND_FUNC, stl_pkg::KIND_INT64, stl_pkg::KIND_RET};
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			mode = stl_pkg::MODE_IDLE;
			pos = '0;
			tbegin = '0;
			hits = '0;
		endfunction

		function bit digit_byte(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function bit letter_byte(logic [7:0] c);
			return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
		endfunction

		function bit blank_byte(logic [7:0] c);
			return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
		endfunction

		// The position sticks at its top value.
		function void bump();
			if (pos != 16'hFFFF) begin
				pos = pos + 16'd1;
			end
		endfunction

		function void owe(logic [3:0] kind, logic [15:0] start, logic [15:0] len,
				logic [7:0] bad);
			stl_pkg::token_t t;
			t.kind = kind;
			t.start = start;
			t.length = len;
			t.bad = bad;
			t.last = 1'b0;
			expected_tokens.insert(expected_tokens.size(), t);
		endfunction

		// Close the pending number or identifier, resolving keywords by candidate and length.
		function void close_token();
			logic [15:0] n;
			logic [3:0]  kind;
			int          i;
			n = pos - tbegin;
			if (mode == stl_pkg::MODE_NUM) begin
				kind = stl_pkg::KIND_NUM;
			end else if (mode == stl_pkg::MODE_IDENT) begin
				kind = stl_pkg::KIND_IDENT;
				for (i = 0; i < 3; i++) begin
					if (hits[i] && n == 16'(kw_word[i].len())) begin
						kind = kw_kinds[i];
					end
				end
			end else begin
				return;
			end
			owe(kind, tbegin, n, 8'h00);
			mode = stl_pkg::MODE_IDLE;
			hits = '0;
		endfunction

		// Note one accepted source beat and queue the tokens it produces.
		function void take_item(logic op, logic [7:0] ch);
			int              already;
			int              i;
			logic [15:0]     idx;
			logic [2:0]      nh;
			logic [3:0]      kind;
			logic [7:0]      bad;
			stl_pkg::token_t t;
			already = expected_tokens.size();
			if (op == stl_pkg::OP_EOS) begin
				close_token();
				owe(stl_pkg::KIND_END, pos, 16'd0, 8'h00);
				clear_scan();
			end else if (mode == stl_pkg::MODE_NUM && digit_byte(ch)) begin
				bump();
			end else if (mode == stl_pkg::MODE_IDENT && (letter_byte(ch) || digit_byte(ch))) begin
				idx = pos - tbegin;
				nh = '0;
				if (pos != 16'hFFFF) begin
					for (i = 0; i < 3; i++) begin
						if (hits[i] && idx < 16'(kw_word[i].len()) &&
								kw_word[i].getc(int'(idx)) == ch) begin
							nh[i] = 1'b1;
						end
					end
				end
				hits = nh;
				bump();
			end else begin
				close_token();
				if (blank_byte(ch)) begin
					// Whitespace only separates tokens.
				end else if (digit_byte(ch)) begin
					mode = stl_pkg::MODE_NUM;
					tbegin = pos;
				end else if (letter_byte(ch)) begin
					mode = stl_pkg::MODE_IDENT;
					tbegin = pos;
					hits = '0;
					for (i = 0; i < 3; i++) begin
						if (kw_word[i].getc(0) == ch) begin
							hits[i] = 1'b1;
						end
					end
				end else begin
					bad = 8'h00;
					case (ch)
						":": kind = stl_pkg::KIND_COLON;
						",": kind = stl_pkg::KIND_COMMA;
						"(": kind = stl_pkg::KIND_LPAREN;
						")": kind = stl_pkg::KIND_RPAREN;
						"{": kind = stl_pkg::KIND_LBRACE;
						"}": kind = stl_pkg::KIND_RBRACE;
						default: begin
							kind = stl_pkg::KIND_UNKNOWN;
							bad = ch;
						end
					endcase
					owe(kind, pos, 16'd1, bad);
				end
				bump();
			end
			if (expected_tokens.size() > already) begin
				t = expected_tokens.pop_back();
				t.last = 1'b1;
				expected_tokens.insert(expected_tokens.size(), t);
			end
		endfunction

		// Compare one result beat against the oldest owed token.
		function void check_token(logic [47:0] d, logic l);
			stl_pkg::token_t e;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token beat: tdata %h tlast %b", d, l);
				errors++;
				return;
			end
			e = expected_tokens.pop_front();
			if (d[3:0] != e.kind) begin
				$error("token_kind: expected %0d, actual %0d", e.kind, d[3:0]);
				errors++;
			end
			if (d[19:4] != e.start) begin
				$error("token_start: expected %0d, actual %0d", e.start, d[19:4]);
				errors++;
			end
			if (d[35:20] != e.length) begin
				$error("token_length: expected %0d, actual %0d", e.length, d[35:20]);
				errors++;
			end
			if (d[43:36] != e.bad) begin
				$error("bad_char: expected %h, actual %h", e.bad, d[43:36]);
				errors++;
			end
			if (d[47:44] != 4'h0) begin
				$error("tdata pad: expected 0, actual %h", d[47:44]);
				errors++;
			end
			if (l != e.last) begin
				$error("last_of_run: expected %b, actual %b", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;

	token_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int sent_items = 0;
	int quiet_cycles = 0;

	string kw_forms[16] = '{"func", "Int64", "ret", "fun", "funcs", "Int6", "Int645", "re",
		"rett", "int64", "Func", "fund", "Ret", "rex", "f", "In"};

	always #4 clk = ~clk;

	script_token_lexer #(
		.POS_WIDTH(LEX_POS_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// Offer one beat, with random idle cycles ahead of it, and wait for acceptance.
	task automatic send_item(logic op, logic [7:0] ch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ch;
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.take_item(op, ch);
		sent_items++;
	endtask

	task automatic send_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_item(stl_pkg::OP_BYTE, s.getc(i));
		end
	endtask

	function automatic logic [7:0] pick(string s);
		return s.getc($urandom_range(0, s.len() - 1));
	endfunction

	function automatic logic [7:0] blank_pick();
		logic [7:0] c;
		c = 8'($urandom_range(8, 13));
		return (c == 8'd8) ? 8'h20 : c;
	endfunction

	// One random token, sometimes followed by whitespace so that neighbors also abut.
	task automatic send_piece();
		int sel;
		int n;
		int i;
		sel = $urandom_range(0, 99);
		if (sel < 22) begin
			send_text(kw_forms[$urandom_range(0, 15)]);
		end else if (sel < 40) begin
			send_item(stl_pkg::OP_BYTE, pick(LETTERS));
			n = $urandom_range(0, 7);
			for (i = 0; i < n; i++) begin
				send_item(stl_pkg::OP_BYTE, pick(ALNUMS));
			end
		end else if (sel < 55) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				send_item(stl_pkg::OP_BYTE, pick(DIGITS));
			end
		end else if (sel < 75) begin
			send_item(stl_pkg::OP_BYTE, pick(PUNCT));
		end else if (sel < 87) begin
			send_item(stl_pkg::OP_BYTE, blank_pick());
		end else if (sel < 97) begin
			send_item(stl_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			send_item(stl_pkg::OP_EOS, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 99) < 45) begin
			send_item(stl_pkg::OP_BYTE, blank_pick());
		end
	endtask

	// Random sources of a few tokens, each closed by end of source.
	task automatic run_phase(int idle_pct, int stall_pct, bit pressure);
		int goal;
		int n;
		int i;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		goal = sent_items + PHASE_ITEMS;
		while (sent_items < goal) begin
			if (pressure && sent_items > goal - PHASE_ITEMS + 100 && hold_req == hold_ack) begin
				hold_req++;
				pressure = 1'b0;
			end
			n = $urandom_range(0, 12);
			for (i = 0; i < n; i++) begin
				send_piece();
			end
			send_item(stl_pkg::OP_EOS, 8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: check accepted beats, then choose tready for the next cycle.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_token(m_tdata, m_tlast);
			end
			if (hold_left == 0 && hold_req != hold_ack) begin
				hold_left = HOLD_CYCLES;
				hold_ack = hold_req;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: too long without any beat on either side ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all punctuation, keywords, an identifier and a number, then an
		// unknown high byte and end of source on both a busy and an empty source.
		send_text("func(a:Int64,9){ret}");
		send_item(stl_pkg::OP_BYTE, 8'h09);
		send_item(stl_pkg::OP_BYTE, 8'hFF);
		send_item(stl_pkg::OP_BYTE, 8'h00);
		send_item(stl_pkg::OP_EOS, 8'hFF);
		send_item(stl_pkg::OP_EOS, 8'h00);
		send_text("ab12 345x");
		send_item(stl_pkg::OP_EOS, 8'h5A);

		run_phase(0, 0, 1'b1);
		run_phase(79, 0, 1'b0);
		run_phase(0, 79, 1'b0);
		run_phase(9, 9, 1'b0);

		s_tvalid <= 1'b0;
		while (sb.expected_tokens.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
